FILE: hw/rtl/edtm_pkg.sv
// Shared types, constants and decode helpers for the EDID timing mode extractor.
// No dependencies; edtm_front, edtm_back, the top level and the testbench import this package.
package edtm_pkg;

    localparam int BLOCK_BYTES      = 128;
    localparam int DESCRIPTOR_COUNT = 4;
    localparam int ADDR_W           = $clog2(BLOCK_BYTES);
    localparam int BUF_BYTES        = 18;
    localparam int BUF_IDX_W        = $clog2(BUF_BYTES + 1);

    localparam logic [ADDR_W-1:0] EST_START  = ADDR_W'(8'h23);
    localparam logic [ADDR_W-1:0] STD_START  = ADDR_W'(8'h26);
    localparam logic [ADDR_W-1:0] DESC_START = ADDR_W'(8'h36);
    localparam logic [ADDR_W-1:0] DESC_SIZE  = ADDR_W'(18);
    localparam logic [7:0]        TAG_STD_LIST = 8'hfa;

    localparam logic [1:0] SRC_EST  = 2'd0;
    localparam logic [1:0] SRC_STD  = 2'd1;
    localparam logic [1:0] SRC_DET  = 2'd2;
    localparam logic [1:0] SRC_DSTD = 2'd3;

    typedef struct packed {
        logic [3:0]  mode_tag;
        logic [11:0] h_pixels;
        logic [11:0] v_lines;
        logic [7:0]  refresh_hz;
        logic [19:0] pclk_khz;
        logic [11:0] h_blank;
        logic [11:0] v_blank;
        logic [9:0]  h_front_porch;
        logic [9:0]  h_sync_len;
        logic [5:0]  v_front_porch;
        logic [5:0]  v_sync_len;
        logic        last_mode;
    } mode_t;

    // front -> back: a complete block sits in the store
    typedef struct packed {
        logic blk_ready;
    } fe_stat_t;

    // back -> front
    typedef struct packed {
        logic busy;
        logic take;
    } be_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EST_LD,
        ST_EST_SCAN,
        ST_STD_LD,
        ST_STD_EMIT,
        ST_DSC_LD,
        ST_DSC_CHK,
        ST_DET_MUL,
        ST_DET_DIV,
        ST_DET_WAIT,
        ST_DET_EMIT,
        ST_FLUSH
    } be_state_t;

    typedef struct packed {
        logic [4:0]  bitpos;
        logic [11:0] h;
        logic [11:0] v;
        logic [7:0]  hz;
    } est_entry_t;

    function automatic est_entry_t est_entry(input logic [3:0] i);
        est_entry_t e;
        case (i)
            4'd0:    e = '{5'd23, 12'd720,  12'd400,  8'd70};
            4'd1:    e = '{5'd22, 12'd720,  12'd400,  8'd88};
            4'd2:    e = '{5'd21, 12'd640,  12'd480,  8'd60};
            4'd3:    e = '{5'd20, 12'd640,  12'd480,  8'd67};
            4'd4:    e = '{5'd19, 12'd640,  12'd480,  8'd72};
            4'd5:    e = '{5'd18, 12'd640,  12'd480,  8'd75};
            4'd6:    e = '{5'd17, 12'd800,  12'd600,  8'd56};
            4'd7:    e = '{5'd16, 12'd800,  12'd600,  8'd60};
            4'd8:    e = '{5'd15, 12'd800,  12'd600,  8'd72};
            4'd9:    e = '{5'd14, 12'd800,  12'd600,  8'd75};
            4'd10:   e = '{5'd13, 12'd832,  12'd624,  8'd75};
            4'd11:   e = '{5'd11, 12'd1024, 12'd768,  8'd60};
            4'd12:   e = '{5'd10, 12'd1024, 12'd768,  8'd70};
            4'd13:   e = '{5'd9,  12'd1024, 12'd768,  8'd75};
            4'd14:   e = '{5'd8,  12'd1280, 12'd1024, 8'd75};
            default: e = '{5'd7,  12'd1152, 12'd870,  8'd75};
        endcase
        return e;
    endfunction

    function automatic logic [ADDR_W-1:0] desc_base(input logic [1:0] d);
        logic [ADDR_W-1:0] off;
        off = ADDR_W'(DESC_SIZE * ADDR_W'(d));
        return DESC_START + off;
    endfunction

    // standard timing pair; h of 256 or less marks an unused slot
    function automatic logic std_used(input logic [7:0] b0);
        logic [11:0] h;
        h = 12'((13'(b0) + 13'd31) << 3);
        return h > 12'd256;
    endfunction

    function automatic mode_t std_mode(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [1:0] src);
        mode_t       m;
        logic [11:0] h;
        logic [13:0] h4;
        logic [31:0] p5;
        logic [13:0] h3;
        logic [15:0] h9;
        h  = 12'((13'(b0) + 13'd31) << 3);
        h4 = 14'(h) << 2;
        p5 = 32'(h4) * 32'd52429;   // x/5 for x below 2^14
        h3 = 14'(h) * 14'd3;
        h9 = 16'(h) * 16'd9;
        m = '0;
        m.mode_tag = {2'b00, src};
        m.h_pixels = h;
        case (b1[7:6])
            2'd0:    m.v_lines = h;
            2'd1:    m.v_lines = 12'(h3 >> 2);
            2'd2:    m.v_lines = 12'(p5 >> 18);
            default: m.v_lines = 12'(h9 >> 4);
        endcase
        m.refresh_hz = 8'({2'b00, b1[5:0]} + 8'd60);
        return m;
    endfunction

endpackage

FILE: hw/rtl/edtm_byte_if.sv
// Input channel of the EDID timing mode extractor: one EDID byte per item.
// Depends on nothing.
interface edtm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] edid_byte;
    logic       block_start;

    modport source (output valid, output edid_byte, output block_start, input ready);
    modport sink   (input valid, input edid_byte, input block_start, output ready);
endinterface

FILE: hw/rtl/edtm_mode_if.sv
// Output channel of the EDID timing mode extractor: one display mode per item.
// Depends on nothing.
interface edtm_mode_if;
    logic        valid;
    logic        ready;
    logic [3:0]  mode_tag;
    logic [11:0] h_pixels;
    logic [11:0] v_lines;
    logic [7:0]  refresh_hz;
    logic [19:0] pclk_khz;
    logic [11:0] h_blank;
    logic [11:0] v_blank;
    logic [9:0]  h_front_porch;
    logic [9:0]  h_sync_len;
    logic [5:0]  v_front_porch;
    logic [5:0]  v_sync_len;
    logic        last_mode;

    modport source (output valid, output mode_tag, output h_pixels, output v_lines,
                    output refresh_hz, output pclk_khz, output h_blank, output v_blank,
                    output h_front_porch, output h_sync_len, output v_front_porch,
                    output v_sync_len, output last_mode, input ready);
    modport sink   (input valid, input mode_tag, input h_pixels, input v_lines,
                    input refresh_hz, input pclk_khz, input h_blank, input v_blank,
                    input h_front_porch, input h_sync_len, input v_front_porch,
                    input v_sync_len, input last_mode, output ready);
endinterface

FILE: hw/rtl/edtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module edtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/edtm_front.sv
// Front end: accepts EDID bytes, writes them to the block store, flags a full block.
// Depends on edtm_pkg and edtm_byte_if.
module edtm_front (
    input  logic                         clk,
    input  logic                         rst_n,
    edtm_byte_if.sink                    byte_in,
    input  edtm_pkg::be_stat_t           be_stat,
    output edtm_pkg::fe_stat_t           fe_stat,
    output logic                         we,
    output logic [edtm_pkg::ADDR_W-1:0]  waddr,
    output logic [7:0]                   wdata
);
    import edtm_pkg::*;

    logic [ADDR_W-1:0] count_reg, count_next;
    logic              pend_reg, pend_next;
    logic              accept;
    logic [ADDR_W-1:0] idx;

    // the store is shared with the back end, so hold off while a block is decoded
    assign byte_in.ready = !pend_reg && !be_stat.busy;
    assign accept        = byte_in.valid && byte_in.ready;
    assign idx           = byte_in.block_start ? '0 : count_reg;
    assign we            = accept;
    assign waddr         = idx;
    assign wdata         = byte_in.edid_byte;
    assign fe_stat.blk_ready = pend_reg;

    always_comb
    begin
        count_next = count_reg;
        pend_next  = pend_reg && !be_stat.take;
        if (accept)
        begin
            count_next = idx + ADDR_W'(1);   // wraps to 0 after the last byte
            if (idx == ADDR_W'(BLOCK_BYTES - 1))
            begin
                pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end
endmodule

FILE: hw/rtl/edtm_div.sv
// Restoring divider, one quotient bit per cycle; returns the low 8 quotient bits.
// Depends on nothing.
module edtm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [29:0] num,
    input  logic [25:0] den,
    output logic        done,
    output logic [7:0]  quo
);
    logic [29:0] num_reg, num_next;
    logic [29:0] q_reg, q_next;
    logic [26:0] rem_reg, rem_next;
    logic [25:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [26:0] trial;

    assign trial = {rem_reg[25:0], num_reg[29]};
    assign done  = done_reg;
    assign quo   = (den_reg == '0) ? 8'd0 : q_reg[7:0];

    always_comb
    begin
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[28:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[28:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd29)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end
endmodule

FILE: hw/rtl/edtm_back.sv
// Back end: walks the stored block, decodes every mode and drives the result register.
// Depends on edtm_pkg and edtm_div.
module edtm_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  edtm_pkg::fe_stat_t           fe_stat,
    output edtm_pkg::be_stat_t           be_stat,
    output logic [edtm_pkg::ADDR_W-1:0]  raddr,
    input  logic [7:0]                   rdata,
    output logic                         out_valid,
    input  logic                         out_ready,
    output edtm_pkg::mode_t              out_mode
);
    import edtm_pkg::*;

    be_state_t           state_reg, state_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [BUF_IDX_W-1:0] n_reg, n_next;
    logic [BUF_IDX_W-1:0] idx_reg, idx_next;
    logic [BUF_IDX_W-1:0] cap_reg, cap_next;
    logic                pend_reg, pend_next;
    logic [3:0]          slot_reg, slot_next;
    logic [1:0]          desc_reg, desc_next;
    logic                in_dsc_reg, in_dsc_next;
    logic [7:0]          buf_reg [BUF_BYTES];
    logic [29:0]         num_reg, num_next;
    logic [25:0]         total_reg, total_next;
    logic [7:0]          hz_reg, hz_next;
    mode_t               hold_reg, hold_next;
    logic                hold_valid_reg, hold_valid_next;
    mode_t               out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                ld_done;
    logic                emit_req;
    mode_t               emit_mode;
    logic                can_emit;
    logic                out_free;
    logic                div_start;
    logic                div_done;
    logic [7:0]          div_quo;
    est_entry_t          est_e;
    logic [23:0]         est_bits;
    logic [11:0]         ha, hb, va, vb;
    logic [12:0]         hsum, vsum;
    logic [15:0]         raw_clk;
    mode_t               det_mode;

    edtm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (total_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign raddr     = base_reg + ADDR_W'(idx_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign can_emit  = !hold_valid_reg || out_free;
    assign out_valid = out_valid_reg;
    assign out_mode  = out_reg;
    assign be_stat.busy = (state_reg != ST_IDLE);
    assign ld_done   = pend_reg && (cap_reg == n_reg - BUF_IDX_W'(1));

    assign est_e    = est_entry(slot_reg);
    assign est_bits = {buf_reg[0], buf_reg[1], buf_reg[2]};

    assign raw_clk = {buf_reg[1], buf_reg[0]};
    assign ha   = {buf_reg[4][7:4], buf_reg[2]};
    assign hb   = {buf_reg[4][3:0], buf_reg[3]};
    assign va   = {buf_reg[7][7:4], buf_reg[5]};
    assign vb   = {buf_reg[7][3:0], buf_reg[6]};
    assign hsum = 13'(ha) + 13'(hb);
    assign vsum = 13'(va) + 13'(vb);

    always_comb
    begin
        det_mode = '0;
        det_mode.mode_tag      = {buf_reg[17][2], buf_reg[17][1], SRC_DET};
        det_mode.h_pixels      = ha;
        det_mode.v_lines       = va;
        det_mode.refresh_hz    = hz_reg;
        det_mode.pclk_khz      = 20'(20'(raw_clk) * 20'd10);
        det_mode.h_blank       = hb;
        det_mode.v_blank       = vb;
        det_mode.h_front_porch = {buf_reg[11][7:6], buf_reg[8]};
        det_mode.h_sync_len    = {buf_reg[11][5:4], buf_reg[9]};
        det_mode.v_front_porch = {buf_reg[11][3:2], buf_reg[10][7:4]};
        det_mode.v_sync_len    = {buf_reg[11][1:0], buf_reg[10][3:0]};
    end

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        cap_next        = cap_reg;
        pend_next       = 1'b0;
        slot_next       = slot_reg;
        desc_next       = desc_reg;
        in_dsc_next     = in_dsc_reg;
        num_next        = num_reg;
        total_next      = total_reg;
        hz_next         = hz_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        emit_req        = 1'b0;
        emit_mode       = '0;
        div_start       = 1'b0;
        be_stat.take    = 1'b0;

        // byte fetch from the store: one read per cycle, data arrives in the next cycle
        if (state_reg == ST_EST_LD || state_reg == ST_STD_LD || state_reg == ST_DSC_LD)
        begin
            if (idx_reg < n_reg)
            begin
                idx_next  = idx_reg + BUF_IDX_W'(1);
                pend_next = 1'b1;
            end
            if (pend_reg)
            begin
                cap_next = cap_reg + BUF_IDX_W'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (fe_stat.blk_ready)
                begin
                    be_stat.take = 1'b1;
                    base_next  = EST_START;
                    n_next     = BUF_IDX_W'(3);
                    idx_next   = '0;
                    cap_next   = '0;
                    state_next = ST_EST_LD;
                end
            end
            ST_EST_LD:
            begin
                if (ld_done)
                begin
                    slot_next  = '0;
                    state_next = ST_EST_SCAN;
                end
            end
            ST_EST_SCAN:
            begin
                emit_mode            = '0;
                emit_mode.mode_tag   = {2'b00, SRC_EST};
                emit_mode.h_pixels   = est_e.h;
                emit_mode.v_lines    = est_e.v;
                emit_mode.refresh_hz = est_e.hz;
                emit_req = est_bits[est_e.bitpos];
                if (!emit_req || can_emit)
                begin
                    if (slot_reg == 4'd15)
                    begin
                        slot_next   = '0;
                        in_dsc_next = 1'b0;
                        base_next   = STD_START;
                        n_next      = BUF_IDX_W'(2);
                        idx_next    = '0;
                        cap_next    = '0;
                        state_next  = ST_STD_LD;
                    end
                    else
                    begin
                        slot_next = slot_reg + 4'd1;
                    end
                end
            end
            ST_STD_LD:
            begin
                if (ld_done)
                begin
                    state_next = ST_STD_EMIT;
                end
            end
            ST_STD_EMIT:
            begin
                emit_mode = std_mode(buf_reg[0], buf_reg[1], in_dsc_reg ? SRC_DSTD : SRC_STD);
                emit_req  = std_used(buf_reg[0]);
                if (!emit_req || can_emit)
                begin
                    if (slot_reg == (in_dsc_reg ? 4'd5 : 4'd7))
                    begin
                        if (!in_dsc_reg)
                        begin
                            desc_next  = '0;
                            base_next  = desc_base(2'd0);
                            n_next     = BUF_IDX_W'(BUF_BYTES);
                            idx_next   = '0;
                            cap_next   = '0;
                            state_next = ST_DSC_LD;
                        end
                        else if (desc_reg == 2'(DESCRIPTOR_COUNT - 1))
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            desc_next  = desc_reg + 2'd1;
                            base_next  = desc_base(desc_reg + 2'd1);
                            n_next     = BUF_IDX_W'(BUF_BYTES);
                            idx_next   = '0;
                            cap_next   = '0;
                            state_next = ST_DSC_LD;
                        end
                    end
                    else
                    begin
                        slot_next  = slot_reg + 4'd1;
                        base_next  = base_reg + ADDR_W'(2);
                        idx_next   = '0;
                        cap_next   = '0;
                        state_next = ST_STD_LD;
                    end
                end
            end
            ST_DSC_LD:
            begin
                if (ld_done)
                begin
                    state_next = ST_DSC_CHK;
                end
            end
            ST_DSC_CHK:
            begin
                if (buf_reg[0] == 8'd0 && buf_reg[1] == 8'd0)
                begin
                    if (buf_reg[3] == TAG_STD_LIST)
                    begin
                        in_dsc_next = 1'b1;
                        slot_next   = '0;
                        base_next   = desc_base(desc_reg) + ADDR_W'(5);
                        n_next      = BUF_IDX_W'(2);
                        idx_next    = '0;
                        cap_next    = '0;
                        state_next  = ST_STD_LD;
                    end
                    else if (desc_reg == 2'(DESCRIPTOR_COUNT - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        desc_next  = desc_reg + 2'd1;
                        base_next  = desc_base(desc_reg + 2'd1);
                        idx_next   = '0;
                        cap_next   = '0;
                        state_next = ST_DSC_LD;
                    end
                end
                else
                begin
                    state_next = ST_DET_MUL;
                end
            end
            ST_DET_MUL:
            begin
                // pixel clock in units of 10 kHz times 10000 gives Hz times 1000/1000
                num_next   = 30'(30'(raw_clk) * 30'd10000);
                total_next = 26'(26'(hsum) * 26'(vsum));
                state_next = ST_DET_DIV;
            end
            ST_DET_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_DET_WAIT;
            end
            ST_DET_WAIT:
            begin
                if (div_done)
                begin
                    hz_next    = div_quo;
                    state_next = ST_DET_EMIT;
                end
            end
            ST_DET_EMIT:
            begin
                emit_mode = det_mode;
                emit_req  = 1'b1;
                if (can_emit)
                begin
                    if (desc_reg == 2'(DESCRIPTOR_COUNT - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        desc_next  = desc_reg + 2'd1;
                        base_next  = desc_base(desc_reg + 2'd1);
                        n_next     = BUF_IDX_W'(BUF_BYTES);
                        idx_next   = '0;
                        cap_next   = '0;
                        state_next = ST_DSC_LD;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next           = hold_reg;
                    out_next.last_mode = 1'b1;
                    out_valid_next     = 1'b1;
                    hold_valid_next    = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // one mode is held back so the final one can carry last_mode
        if (emit_req && can_emit)
        begin
            if (hold_valid_reg)
            begin
                out_next       = hold_reg;
                out_valid_next = 1'b1;
            end
            hold_next       = emit_mode;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cap_reg        <= '0;
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cap_reg        <= cap_next;
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        n_reg      <= n_next;
        slot_reg   <= slot_next;
        desc_reg   <= desc_next;
        in_dsc_reg <= in_dsc_next;
        num_reg    <= num_next;
        total_reg  <= total_next;
        hz_reg     <= hz_next;
        hold_reg   <= hold_next;
        out_reg    <= out_next;
        if (pend_reg)
        begin
            buf_reg[cap_reg[$clog2(BUF_BYTES)-1:0]] <= rdata;
        end
    end
endmodule

FILE: hw/rtl/edid_timing_mode_extractor.sv
// Top level of the EDID timing mode extractor: front end, block store, back end.
// Depends on edtm_pkg, edtm_byte_if, edtm_mode_if, edtm_ram, edtm_front, edtm_back.
//
// Feed a 128-byte EDID base block one byte per item; block_start restarts the byte
// count at zero, and after byte 127 the count wraps by itself. Each accepted byte is
// written into the block store. Once the last byte lands, the back end walks the store
// and emits every mode in file order: established timings, the 8 standard slots
// (unused slots dropped), then the 4 descriptors (detailed timing or an 0xFA list of
// six standard timings; other descriptors give no mode). last_mode marks the final
// mode; a block with no modes emits nothing. While a block is being decoded the input
// stays not ready. Decode time is set by the single read port of the store (one byte
// per cycle) and by the refresh divider, which runs 30 iterations per detailed
// descriptor. The back end starts, loads and scans the established timings, then the
// standard slots, then each descriptor, and flushes the held mode at the end.
// No checksum is checked.
module edid_timing_mode_extractor (
    input  logic        clk,
    input  logic        rst_n,
    edtm_byte_if.sink   byte_in,
    edtm_mode_if.source mode_out
);
    import edtm_pkg::*;

    fe_stat_t          fe_stat;
    be_stat_t          be_stat;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;
    mode_t             mode;

    edtm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .be_stat (be_stat),
        .fe_stat (fe_stat),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata)
    );

    // block store, written by the front end, read by the back end
    edtm_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    edtm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fe_stat   (fe_stat),
        .be_stat   (be_stat),
        .raddr     (raddr),
        .rdata     (rdata),
        .out_valid (mode_out.valid),
        .out_ready (mode_out.ready),
        .out_mode  (mode)
    );

    assign mode_out.mode_tag      = mode.mode_tag;
    assign mode_out.h_pixels      = mode.h_pixels;
    assign mode_out.v_lines       = mode.v_lines;
    assign mode_out.refresh_hz    = mode.refresh_hz;
    assign mode_out.pclk_khz      = mode.pclk_khz;
    assign mode_out.h_blank       = mode.h_blank;
    assign mode_out.v_blank       = mode.v_blank;
    assign mode_out.h_front_porch = mode.h_front_porch;
    assign mode_out.h_sync_len    = mode.h_sync_len;
    assign mode_out.v_front_porch = mode.v_front_porch;
    assign mode_out.v_sync_len    = mode.v_sync_len;
    assign mode_out.last_mode     = mode.last_mode;

    // store is never written while the back end reads it
    assert property (@(posedge clk) disable iff (!rst_n) we |-> !be_stat.busy)
        else $error("store written during decode");

    // the back end only takes a block the front end has flagged
    assert property (@(posedge clk) disable iff (!rst_n) be_stat.take |-> fe_stat.blk_ready)
        else $error("decode started without a complete block");

    // the last byte of a block closes the input on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (we && waddr == ADDR_W'(BLOCK_BYTES - 1)) |=> !byte_in.ready)
        else $error("input still open after a complete block");
endmodule

FILE: test/tb.sv
// Testbench for edid_timing_mode_extractor: streams EDID blocks byte by byte and checks modes.
// Depends on edtm_pkg, edtm_byte_if, edtm_mode_if and the RTL top level.
`timescale 1ns / 100ps

module tb;
    import edtm_pkg::*;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int TAIL_CYCLES     = 400;

    typedef struct {
        logic [7:0] data;
        logic       start;
        bit         drain_first;   // hold off until all modes so far are back
    } byte_item_t;

    logic clk;
    logic rst_n;

    edtm_byte_if byte_ch ();
    edtm_mode_if mode_ch ();

    edid_timing_mode_extractor i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_ch),
        .mode_out (mode_ch)
    );

    // stimulus and expectation stores
    byte_item_t pending_bytes[$];
    mode_t      expected_modes[$];
    logic [7:0] edid_copy[BLOCK_BYTES];
    int         edid_count;
    logic [7:0] blk[BLOCK_BYTES];

    int  cycle_no;
    int  quiet_cycles;
    int  fail_count;

    // established timing table: bit position, h, v, refresh
    int est_bit[16] = '{23, 22, 21, 20, 19, 18, 17, 16, 15, 14, 13, 11, 10, 9, 8, 7};
    int est_h[16]   = '{720, 720, 640, 640, 640, 640, 800, 800, 800, 800, 832,
                        1024, 1024, 1024, 1280, 1152};
    int est_v[16]   = '{400, 400, 480, 480, 480, 480, 600, 600, 600, 600, 624,
                        768, 768, 768, 1024, 870};
    int est_hz[16]  = '{70, 88, 60, 67, 72, 75, 56, 60, 72, 75, 75, 60, 70, 75, 75, 75};

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // standard timing pair; returns 0 for an unused slot
    function automatic bit std_pair(input int pos, input logic [1:0] src, output mode_t m);
        int h;
        int b1;
        h  = (int'(edid_copy[pos % BLOCK_BYTES]) + 31) * 8;
        b1 = edid_copy[(pos + 1) % BLOCK_BYTES];
        m  = '0;
        if (h <= 256)
            return 0;
        m.mode_tag   = {2'b00, src};
        m.h_pixels   = 12'(h);
        case ((b1 >> 6) & 3)
            0:       m.v_lines = 12'(h);
            1:       m.v_lines = 12'(h * 3 / 4);
            2:       m.v_lines = 12'(h * 4 / 5);
            default: m.v_lines = 12'(h * 9 / 16);
        endcase
        m.refresh_hz = 8'((b1 & 8'h3f) + 60);
        return 1;
    endfunction

    function automatic mode_t detailed_mode(input int p);
        mode_t   m;
        longint  khz;
        longint  total;
        int      ha;
        int      hb;
        int      va;
        int      vb;
        khz = ((longint'(edid_copy[p + 1]) << 8) | edid_copy[p]) * 10;
        ha  = (int'(edid_copy[p + 4] >> 4) << 8) | edid_copy[p + 2];
        hb  = (int'(edid_copy[p + 4] & 8'h0f) << 8) | edid_copy[p + 3];
        va  = (int'(edid_copy[p + 7] >> 4) << 8) | edid_copy[p + 5];
        vb  = (int'(edid_copy[p + 7] & 8'h0f) << 8) | edid_copy[p + 6];
        total = longint'(ha + hb) * longint'(va + vb);
        m = '0;
        m.mode_tag      = {edid_copy[p + 17][2], edid_copy[p + 17][1], SRC_DET};
        m.h_pixels      = 12'(ha);
        m.v_lines       = 12'(va);
        // zero total gives refresh 0
        m.refresh_hz    = (total == 0) ? 8'd0 : 8'((khz * 1000) / total);
        m.pclk_khz      = 20'(khz);
        m.h_blank       = 12'(hb);
        m.v_blank       = 12'(vb);
        m.h_front_porch = {edid_copy[p + 11][7:6], edid_copy[p + 8]};
        m.h_sync_len    = {edid_copy[p + 11][5:4], edid_copy[p + 9]};
        m.v_front_porch = {edid_copy[p + 11][3:2], edid_copy[p + 10][7:4]};
        m.v_sync_len    = {edid_copy[p + 11][1:0], edid_copy[p + 10][3:0]};
        return m;
    endfunction

    // full decode of the stored block, in file order
    task automatic decode_block();
        mode_t block_modes[$];
        mode_t m;
        int    est;
        int    p;
        est = (int'(edid_copy[8'h23]) << 16) | (int'(edid_copy[8'h24]) << 8) | edid_copy[8'h25];
        for (int i = 0; i < 16; i++)
        begin
            if ((est >> est_bit[i]) & 1)
            begin
                m = '0;
                m.mode_tag   = {2'b00, SRC_EST};
                m.h_pixels   = 12'(est_h[i]);
                m.v_lines    = 12'(est_v[i]);
                m.refresh_hz = 8'(est_hz[i]);
                block_modes.push_back(m);
            end
        end
        for (int i = 0; i < 8; i++)
            if (std_pair(8'h26 + 2 * i, SRC_STD, m))
                block_modes.push_back(m);
        for (int d = 0; d < DESCRIPTOR_COUNT; d++)
        begin
            p = 8'h36 + 18 * d;
            if (edid_copy[p] == 8'h00 && edid_copy[p + 1] == 8'h00)
            begin
                if (edid_copy[p + 3] == TAG_STD_LIST)
                    for (int j = 0; j < 6; j++)
                        if (std_pair(p + 5 + 2 * j, SRC_DSTD, m))
                            block_modes.push_back(m);
            end
            else
                block_modes.push_back(detailed_mode(p));
        end
        if (block_modes.size() > 0)
            block_modes[$].last_mode = 1'b1;
        foreach (block_modes[i])
            expected_modes.push_back(block_modes[i]);
    endtask

    task automatic take_byte(input logic [7:0] data, input logic start);
        if (start)
            edid_count = 0;
        if (edid_count >= BLOCK_BYTES)
            edid_count = 0;
        edid_copy[edid_count] = data;
        edid_count++;
        if (edid_count == BLOCK_BYTES)
        begin
            edid_count = 0;
            decode_block();
        end
    endtask

    task automatic queue_bytes(input int n, input bit drain);
        byte_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.data        = blk[i];
            it.start       = (i == 0);
            it.drain_first = drain && (i == 0);
            pending_bytes.push_back(it);
        end
    endtask

    // kind: 0 detailed, 1 0xFA list, 2 other display descriptor, 3 zero-total detailed
    task automatic fill_descriptor(input int d, input int kind);
        int p;
        p = 8'h36 + 18 * d;
        for (int i = 0; i < 18; i++)
            blk[p + i] = 8'($urandom_range(0, 255));
        case (kind)
            0:
            begin
                if (blk[p] == 8'h00 && blk[p + 1] == 8'h00)
                    blk[p] = 8'h01;
            end
            1:
            begin
                blk[p] = 8'h00;
                blk[p + 1] = 8'h00;
                blk[p + 3] = TAG_STD_LIST;
                for (int j = 0; j < 6; j++)
                    if ($urandom_range(0, 3) == 0)
                        blk[p + 5 + 2 * j] = 8'($urandom_range(0, 1));
            end
            2:
            begin
                blk[p] = 8'h00;
                blk[p + 1] = 8'h00;
                if (blk[p + 3] == TAG_STD_LIST)
                    blk[p + 3] = 8'hfc;
            end
            default:
            begin
                blk[p + 1] = 8'($urandom_range(1, 255));
                blk[p + 2] = 8'h00;
                blk[p + 3] = 8'h00;
                blk[p + 4] = 8'h00;
            end
        endcase
    endtask

    task automatic random_block();
        for (int i = 0; i < BLOCK_BYTES; i++)
            blk[i] = 8'($urandom_range(0, 255));
        // some unused standard slots (256 and below)
        for (int i = 0; i < 8; i++)
            if ($urandom_range(0, 3) == 0)
                blk[8'h26 + 2 * i] = 8'($urandom_range(0, 1));
        for (int d = 0; d < DESCRIPTOR_COUNT; d++)
            fill_descriptor(d, $urandom_range(0, 4) == 0 ? $urandom_range(2, 3)
                                                         : $urandom_range(0, 1));
    endtask

    // field check: one line per mismatch
    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t mode field %s: expected %0d, actual %0d", $realtime, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    function automatic bit idle_now();
        // quiet stretch with no idling between these cycles
        if (cycle_no > 150 && cycle_no < 650)
            return 0;
        return $urandom_range(0, 99) < 27;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid       <= 1'b0;
            byte_ch.edid_byte   <= 8'h00;
            byte_ch.block_start <= 1'b0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                take_byte(byte_ch.edid_byte, byte_ch.block_start);
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (pending_bytes.size() > 0 && !idle_now() &&
                    !(pending_bytes[0].drain_first && expected_modes.size() > 0))
                begin
                    byte_ch.valid       <= 1'b1;
                    byte_ch.edid_byte   <= pending_bytes[0].data;
                    byte_ch.block_start <= pending_bytes[0].start;
                    void'(pending_bytes.pop_front());
                end
                else
                    byte_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: random backpressure, compare against the oldest expected mode
    always @(posedge clk or negedge rst_n)
    begin
        mode_t want;
        if (!rst_n)
            mode_ch.ready <= 1'b0;
        else
        begin
            mode_ch.ready <= !idle_now();
            if (mode_ch.valid && mode_ch.ready)
            begin
                if (expected_modes.size() == 0)
                begin
                    $display("%0t unexpected mode: expected none, actual h %0d v %0d",
                             $realtime, mode_ch.h_pixels, mode_ch.v_lines);
                    fail_count++;
                end
                else
                begin
                    want = expected_modes.pop_front();
                    check_field("mode_tag", want.mode_tag, mode_ch.mode_tag);
                    check_field("h_pixels", want.h_pixels, mode_ch.h_pixels);
                    check_field("v_lines", want.v_lines, mode_ch.v_lines);
                    check_field("refresh_hz", want.refresh_hz, mode_ch.refresh_hz);
                    check_field("pclk_khz", want.pclk_khz, mode_ch.pclk_khz);
                    check_field("h_blank", want.h_blank, mode_ch.h_blank);
                    check_field("v_blank", want.v_blank, mode_ch.v_blank);
                    check_field("h_front_porch", want.h_front_porch, mode_ch.h_front_porch);
                    check_field("h_sync_len", want.h_sync_len, mode_ch.h_sync_len);
                    check_field("v_front_porch", want.v_front_porch, mode_ch.v_front_porch);
                    check_field("v_sync_len", want.v_sync_len, mode_ch.v_sync_len);
                    check_field("last_mode", want.last_mode, mode_ch.last_mode);
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if ((byte_ch.valid && byte_ch.ready) || (mode_ch.valid && mode_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        cycle_no     = 0;
        quiet_cycles = 0;
        fail_count   = 0;
        edid_count   = 0;
        rst_n        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // a few bytes of a block, then a restart with block_start
        random_block();
        queue_bytes(6, 0);
        // all ones: every established bit, full standard slots, maximal detailed fields
        foreach (blk[i]) blk[i] = 8'hff;
        queue_bytes(BLOCK_BYTES, 0);
        // 0xFA list, other display descriptor, zero-total detailed, plain detailed;
        // byte 0 comes without block_start, so the count has to wrap by itself
        random_block();
        fill_descriptor(0, 1);
        fill_descriptor(1, 2);
        fill_descriptor(2, 3);
        fill_descriptor(3, 0);
        queue_bytes(BLOCK_BYTES, 1);
        pending_bytes[$ - (BLOCK_BYTES - 1)].start = 1'b0;
        // all zero: no mode at all
        foreach (blk[i]) blk[i] = 8'h00;
        queue_bytes(BLOCK_BYTES, 1);

        wait (pending_bytes.size() == 0 && !byte_ch.valid);
        wait (expected_modes.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_modes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
